// ----- sv/gamepad_input_conditioner_defines.svh -----
// assertion macros for the gamepad input conditioner checker
// no dependencies; included by files that hold concurrent assertions
`ifndef GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH

// same-cycle implication under an active-low reset
`define GIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gic check failed");

// next-cycle implication under an active-low reset
`define GIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gic check failed");

`endif

// ----- sv/gic_pkg.sv -----
// shared types and constants of the gamepad input conditioner
// no dependencies; used by every lane module and the top level
package gic_pkg;

  // command codes
  localparam logic CmdScan = 1'b0;
  localparam logic CmdMark = 1'b1;

  // configuration register indexes
  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegCenter   = 2'd1;
  localparam logic [1:0] RegDeadzone = 2'd2;

  // configuration reset values
  localparam logic [7:0] DebounceRst = 8'd5;
  localparam logic [7:0] CenterRst   = 8'd128;
  localparam logic [7:0] DeadzoneRst = 8'd8;

  // switch position codes
  localparam logic [1:0] SwMid  = 2'd0;
  localparam logic [1:0] SwUp   = 2'd1;
  localparam logic [1:0] SwDown = 2'd2;

  localparam int unsigned MaxButtons = 6;
  localparam int unsigned Switches   = 3;
  localparam int unsigned Sticks     = 4;

  // per-item lane control
  typedef struct packed {
    logic scan_en;   // primed scan: lanes update
    logic prime_en;  // first scan: only encoder levels are recorded
    logic clear;     // mark sent: counts cleared
  } lane_ctrl_t;

endpackage

// ----- sv/gic_button_lane.sv -----
// one debounce lane for an active-low button
// depends on gic_pkg (lane_ctrl_t)
module gic_button_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gic_pkg::lane_ctrl_t ctrl_i,
  input  logic              pin_i,
  input  logic [7:0]        debounce_count_i,
  output logic              stable_o,
  output logic              chg_o
);

  logic       stable_q, stable_d;
  logic [7:0] timer_q, timer_d;
  logic [7:0] timer_inc;
  logic       raw;

  always_comb begin
    raw       = ~pin_i;
    timer_inc = timer_q + 8'd1;
    stable_d  = stable_q;
    timer_d   = timer_q;
    chg_o     = 1'b0;
    if (raw != stable_q) begin
      if (timer_inc >= debounce_count_i) begin
        stable_d = raw;
        timer_d  = 8'd0;
        chg_o    = 1'b1;
      end else begin
        timer_d = timer_inc;
      end
    end else begin
      timer_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      timer_q  <= 8'd0;
    end else if (ctrl_i.scan_en) begin
      stable_q <= stable_d;
      timer_q  <= timer_d;
    end
  end

  assign stable_o = stable_q;

endmodule

// ----- sv/gic_stick_lane.sv -----
// one joystick axis lane: cut to 8 bits and snap to center in the deadzone
// depends on gic_pkg (lane_ctrl_t)
module gic_stick_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gic_pkg::lane_ctrl_t ctrl_i,
  input  logic [11:0]       sample_i,
  input  logic [7:0]        center_i,
  input  logic [7:0]        deadzone_i,
  output logic [7:0]        value_o,
  output logic              chg_o
);

  logic [7:0]        value_q, value_d;
  logic signed [9:0] lo, hi, v_s;

  always_comb begin
    lo      = $signed({2'b00, center_i}) - $signed({2'b00, deadzone_i});
    hi      = $signed({2'b00, center_i}) + $signed({2'b00, deadzone_i});
    v_s     = $signed({2'b00, sample_i[11:4]});
    value_d = ((v_s > lo) && (v_s < hi)) ? center_i : sample_i[11:4];
    chg_o   = (value_d != value_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= 8'd0;
    end else if (ctrl_i.scan_en) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ----- sv/gic_quad_lane.sv -----
// one quadrature decoder lane, 4x counting into a wrapping 8-bit total
// depends on gic_pkg (lane_ctrl_t)
module gic_quad_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gic_pkg::lane_ctrl_t ctrl_i,
  input  logic [1:0]        ab_i,
  output logic signed [7:0] total_o,
  output logic              chg_o
);

  logic [1:0]        prev_q;
  logic signed [7:0] total_q;
  logic signed [2:0] delta;
  logic              a, b;

  always_comb begin
    a     = ab_i[0];
    b     = ab_i[1];
    delta = 3'sd0;
    if (a != prev_q[0]) begin
      delta = (a != b) ? delta + 3'sd1 : delta - 3'sd1;
    end
    if (b != prev_q[1]) begin
      delta = (a == b) ? delta + 3'sd1 : delta - 3'sd1;
    end
    chg_o = (delta != 3'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 2'b00;
      total_q <= 8'sd0;
    end else begin
      if (ctrl_i.scan_en || ctrl_i.prime_en) begin
        prev_q <= ab_i;
      end
      if (ctrl_i.clear) begin
        total_q <= 8'sd0;
      end else if (ctrl_i.scan_en && chg_o) begin
        total_q <= total_q + {{5{delta[2]}}, delta};
      end
    end
  end

  assign total_o = total_q;

endmodule

// ----- sv/gamepad_input_conditioner.sv -----
// gamepad input conditioner: a result is valid the cycle after its item is
// accepted; one item per cycle while the output is not stalled, set by the
// registered lane update and the output register that parts the channels
// reset: asynchronous active low; lanes clear to released/mid/zero, counts 0,
// encoders unprimed, registers take debounce 5, center 128, deadzone 8
// depends on gic_pkg, gic_button_lane, gic_stick_lane, gic_quad_lane
module gamepad_input_conditioner #(
  parameter int unsigned BUTTONS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [5:0]        button_pins_i,
  input  logic [5:0]        switch_pins_i,
  input  logic [11:0]       left_x_sample_i,
  input  logic [11:0]       left_y_sample_i,
  input  logic [11:0]       right_x_sample_i,
  input  logic [11:0]       right_y_sample_i,
  input  logic [3:0]        encoder_pins_i,
  input  logic [1:0]        push_pins_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        left_x_o,
  output logic [7:0]        left_y_o,
  output logic [7:0]        right_x_o,
  output logic [7:0]        right_y_o,
  output logic [5:0]        button_bits_o,
  output logic [5:0]        switch_bits_o,
  output logic signed [7:0] enc1_count_o,
  output logic signed [7:0] enc2_count_o,
  output logic [1:0]        push_bits_o,
  output logic              changed_o
);

  // configuration registers
  logic [7:0] debounce_q, center_q, deadzone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= gic_pkg::DebounceRst;
      center_q   <= gic_pkg::CenterRst;
      deadzone_q <= gic_pkg::DeadzoneRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gic_pkg::RegDebounce: debounce_q <= cfg_data_i;
        gic_pkg::RegCenter:   center_q   <= cfg_data_i;
        gic_pkg::RegDeadzone: deadzone_q <= cfg_data_i;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // handshake: the lane state doubles as the output register, so an item
  // is taken whenever the previous result is gone or leaves this cycle
  logic accept, scan, mark;
  logic out_valid_q, out_valid_d;
  logic primed_q;
  gic_pkg::lane_ctrl_t ctrl;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign scan       = accept & (command_i == gic_pkg::CmdScan);
  assign mark       = accept & (command_i == gic_pkg::CmdMark);

  // the first scan after reset only primes the encoder level history
  assign ctrl.scan_en  = scan & primed_q;
  assign ctrl.prime_en = scan & ~primed_q;
  assign ctrl.clear    = mark;

  assign out_valid_d = accept | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctrl.prime_en) begin
        primed_q <= 1'b1;
      end
    end
  end

  // button lanes; positions past BUTTONS read released
  logic [5:0] btn_chg;

  for (genvar i = 0; i < gic_pkg::MaxButtons; i++) begin : g_btn
    if (i < BUTTONS) begin : g_lane
      gic_button_lane u_lane (
        .clk_i            (clk_i),
        .rst_ni           (rst_ni),
        .ctrl_i           (ctrl),
        .pin_i            (button_pins_i[i]),
        .debounce_count_i (debounce_q),
        .stable_o         (button_bits_o[i]),
        .chg_o            (btn_chg[i])
      );
    end else begin : g_off
      assign button_bits_o[i] = 1'b0;
      assign btn_chg[i]       = 1'b0;
    end
  end

  // stick lanes
  logic [gic_pkg::Sticks-1:0][11:0] samples;
  logic [gic_pkg::Sticks-1:0][7:0]  stick_val;
  logic [gic_pkg::Sticks-1:0]       stick_chg;

  assign samples = {right_y_sample_i, right_x_sample_i, left_y_sample_i, left_x_sample_i};

  for (genvar i = 0; i < gic_pkg::Sticks; i++) begin : g_stick
    gic_stick_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sample_i   (samples[i]),
      .center_i   (center_q),
      .deadzone_i (deadzone_q),
      .value_o    (stick_val[i]),
      .chg_o      (stick_chg[i])
    );
  end

  assign left_x_o  = stick_val[0];
  assign left_y_o  = stick_val[1];
  assign right_x_o = stick_val[2];
  assign right_y_o = stick_val[3];

  // encoder lanes
  logic enc1_chg, enc2_chg;

  gic_quad_lane u_enc1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .ab_i    (encoder_pins_i[1:0]),
    .total_o (enc1_count_o),
    .chg_o   (enc1_chg)
  );

  gic_quad_lane u_enc2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .ab_i    (encoder_pins_i[3:2]),
    .total_o (enc2_count_o),
    .chg_o   (enc2_chg)
  );

  // switches: both or neither pin active reads mid
  logic [gic_pkg::Switches-1:0][1:0] sw_q, sw_d;
  logic [gic_pkg::Switches-1:0]      sw_chg;
  logic                              sw_up, sw_dn;

  always_comb begin
    sw_up = 1'b0;
    sw_dn = 1'b0;
    for (int i = 0; i < gic_pkg::Switches; i++) begin
      sw_up = ~switch_pins_i[2*i];
      sw_dn = ~switch_pins_i[2*i+1];
      if (sw_up && !sw_dn) begin
        sw_d[i] = gic_pkg::SwUp;
      end else if (!sw_up && sw_dn) begin
        sw_d[i] = gic_pkg::SwDown;
      end else begin
        sw_d[i] = gic_pkg::SwMid;
      end
      sw_chg[i] = (sw_d[i] != sw_q[i]);
    end
  end

  // push buttons pass through
  logic [1:0] push_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= '0;
      push_q <= 2'b00;
    end else if (ctrl.scan_en) begin
      sw_q   <= sw_d;
      push_q <= push_pins_i;
    end
  end

  assign switch_bits_o = sw_q;
  assign push_bits_o   = push_q;

  // merge: any lane that moved sets the flag, a mark clears it
  logic changed_q, any_chg;

  assign any_chg = (|btn_chg) | (|stick_chg) | enc1_chg | enc2_chg | (|sw_chg)
                 | (push_pins_i != push_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      changed_q <= 1'b0;
    end else if (mark) begin
      changed_q <= 1'b0;
    end else if (ctrl.scan_en && any_chg) begin
      changed_q <= 1'b1;
    end
  end

  assign changed_o   = changed_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/gic_checker.sv -----
// port-level checker for the gamepad input conditioner, bound to the top
// depends on gamepad_input_conditioner_defines.svh and the top-level ports
`include "gamepad_input_conditioner_defines.svh"

module gic_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              command_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [5:0]        button_bits_o,
  input logic [5:0]        switch_bits_o,
  input logic signed [7:0] enc1_count_o,
  input logic signed [7:0] enc2_count_o,
  input logic              changed_o
);

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_o;

  // an empty output stage never blocks the input
  `GIC_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // a stalled result stays offered
  `GIC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // mark sent clears counts and flag in the result it produces
  `GIC_ASSERT_NEXT(a_mark_clears, clk_i, rst_ni, in_acc && command_i,
    out_valid_o && !changed_o && enc1_count_o == 8'sd0 && enc2_count_o == 8'sd0)

  // state moves only when an item is taken
  `GIC_ASSERT_NEXT(a_state_only_on_item, clk_i, rst_ni, !in_acc,
    $stable(button_bits_o) && $stable(switch_bits_o) && $stable(enc1_count_o)
    && $stable(enc2_count_o) && $stable(changed_o))

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .button_bits_o (button_bits_o),
  .switch_bits_o (switch_bits_o),
  .enc1_count_o  (enc1_count_o),
  .enc2_count_o  (enc2_count_o),
  .changed_o     (changed_o)
);
